// ----- sv/fdc32_pkg.sv -----
// Shared types, constants and the CRC-32 byte update for the frame deframer.
package fdc32_pkg;

  localparam int HDR_BYTES      = 22;
  localparam int COUNT_W        = 11;
  localparam int HDR_IDX_W      = 5;
  localparam int MAX_BODY_BYTES = 1024;
  localparam int MID_DEPTH      = 2;
  localparam int OUT_DEPTH      = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [31:0]        CRC_INIT  = 32'hFFFF_FFFF;
  localparam logic [31:0]        CRC_POLY  = 32'hEDB8_8320;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] REG_START_WORD    = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAJOR_VERSION = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_LEN    = 3'd1,
    ST_BAD_START  = 3'd2,
    ST_BAD_VER    = 3'd3,
    ST_TOO_LARGE  = 3'd4,
    ST_CRC_ERR    = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    logic [2:0]  status;
    logic [15:0] message_id;
    logic [15:0] header_flags;
    logic [31:0] session_number;
    logic [31:0] sequence_number;
    logic [15:0] body_length;
    logic [7:0]  minor_version;
  } out_item_t;

  // Beat handed from front to back: result with provisional status, plus
  // what the back needs for the final CRC verdict.
  typedef struct packed {
    out_item_t   res;
    logic        crc_chk;
    logic        body_nz;
    logic [31:0] hdr_crc;
  } mid_item_t;

  // Reflected CRC-32, one byte, eight bit steps unrolled.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/frame_deframer_crc32_check_unit.sv -----
// Path: an accepted byte is written to the mid queue, then the CRC logic writes the result
// queue, which out_data reads first-word fall-through.
// Throughput: one byte per cycle while full is low; the CRC byte update is unrolled, no loop.
// Stalls: up to four beats wait (two per queue); full mirrors the mid queue's full flag.
// Reset (rst_n low, synchronous): both queues empty, byte position 0, CRC all ones,
// start_word 0, major_version 1. Header byte store is not cleared.
module frame_deframer_crc32_check_unit #(
  parameter int MID_DEPTH = fdc32_pkg::MID_DEPTH,
  parameter int OUT_DEPTH = fdc32_pkg::OUT_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input byte beats
  input  logic                             push,
  output logic                             full,
  input  fdc32_pkg::in_item_t              in_data,
  // result beats
  output logic                             empty,
  input  logic                             pop,
  output fdc32_pkg::out_item_t             out_data,
  // configuration writes
  input  logic                             cfg_wr_en,
  input  logic [fdc32_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fdc32_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                 mid_push, mid_full, mid_pop, mid_empty;
  fdc32_pkg::mid_item_t mid_wr, mid_rd;
  logic                 out_push, out_full;
  fdc32_pkg::out_item_t out_wr;

  // Front: tracks byte position, stores the 22 header bytes and does every
  // check except the CRC compare. A last beat leaves with the header fields
  // attached, so the front may start on the next frame straight away.
  fdc32_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (push),
    .in_data   (in_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mid_full  (mid_full),
    .mid_push  (mid_push),
    .mid_item  (mid_wr)
  );

  // Short queue between the two halves.
  fdc32_fifo #(
    .WIDTH ($bits(fdc32_pkg::mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wr),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rd),
    .empty (mid_empty)
  );

  // Back: folds payload bytes into the CRC and settles the final status.
  fdc32_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_item  (mid_rd),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_item  (out_wr)
  );

  // Result queue; decouples the consumer's pop from the CRC stage.
  fdc32_fifo #(
    .WIDTH ($bits(fdc32_pkg::out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_wr),
    .full  (out_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

  assign full = mid_full;

  // Reset leaves no stale result beat behind.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // An accepted byte always lands in the inter-stage queue.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |=> !mid_empty)
    else $error("accepted beat lost before back end");

  // Only a last-byte result carries a status.
  a_status_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && (out_data.status != fdc32_pkg::ST_OK)) |-> out_data.frame_done)
    else $error("status reported on non-final beat");

  // Header bytes never leak onto the payload lane.
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_data.payload_valid) |-> (out_data.payload_byte == 8'd0))
    else $error("payload byte set on header beat");

endmodule

// ----- sv/fdc32_fifo.sv -----
// Small register queue with first-word fall-through read.
module fdc32_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ----- sv/fdc32_front.sv -----
// Front end: byte position, header capture, config registers, header checks.
module fdc32_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  fdc32_pkg::in_item_t                  in_data,
  input  logic                                 cfg_wr_en,
  input  logic [fdc32_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [fdc32_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic                                 mid_full,
  output logic                                 mid_push,
  output fdc32_pkg::mid_item_t                 mid_item
);

  localparam int CMP_W = 17;

  logic [fdc32_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]                    hdr_r [fdc32_pkg::HDR_BYTES];
  logic [15:0]                   start_word_r;
  logic [7:0]                    major_version_r;

  logic        accept, is_payload, is_short, len_ok;
  logic [7:0]  b21;
  logic [15:0] sw, body_len;
  logic [31:0] hdr_crc;
  fdc32_pkg::status_t pre_st;

  assign accept   = in_push && !mid_full;
  assign mid_push = accept;

  always_comb begin
    is_payload = (cnt_r >= fdc32_pkg::COUNT_W'(fdc32_pkg::HDR_BYTES));
    is_short   = (cnt_r <  fdc32_pkg::COUNT_W'(fdc32_pkg::HDR_BYTES - 1));
    // top header byte may be the byte arriving now
    b21        = (cnt_r == fdc32_pkg::COUNT_W'(fdc32_pkg::HDR_BYTES - 1)) ?
                 in_data.rx_byte : hdr_r[21];
    sw         = {hdr_r[1], hdr_r[0]};
    body_len   = {hdr_r[17], hdr_r[16]};
    hdr_crc    = {b21, hdr_r[20], hdr_r[19], hdr_r[18]};
    len_ok     = (cnt_r != fdc32_pkg::COUNT_MAX) &&
                 ((CMP_W'(cnt_r) + CMP_W'(1)) ==
                  (CMP_W'(body_len) + CMP_W'(fdc32_pkg::HDR_BYTES)));

    if (is_short) begin
      pre_st = fdc32_pkg::ST_BAD_LEN;
    end else if (sw != start_word_r) begin
      pre_st = fdc32_pkg::ST_BAD_START;
    end else if (hdr_r[2] != major_version_r) begin
      pre_st = fdc32_pkg::ST_BAD_VER;
    end else if (body_len > 16'(fdc32_pkg::MAX_BODY_BYTES)) begin
      pre_st = fdc32_pkg::ST_TOO_LARGE;
    end else if (!len_ok) begin
      pre_st = fdc32_pkg::ST_BAD_LEN;
    end else begin
      pre_st = fdc32_pkg::ST_OK;
    end

    mid_item = '0;
    mid_item.res.payload_byte  = is_payload ? in_data.rx_byte : 8'd0;
    mid_item.res.payload_valid = is_payload;
    if (in_data.last_byte) begin
      mid_item.res.frame_done = 1'b1;
      mid_item.res.status     = pre_st;
      mid_item.crc_chk        = !is_short && (pre_st == fdc32_pkg::ST_OK);
      mid_item.body_nz        = (body_len != 16'd0);
      mid_item.hdr_crc        = hdr_crc;
      if (!is_short) begin
        mid_item.res.message_id      = {hdr_r[5], hdr_r[4]};
        mid_item.res.header_flags    = {hdr_r[7], hdr_r[6]};
        mid_item.res.session_number  = {hdr_r[11], hdr_r[10], hdr_r[9], hdr_r[8]};
        mid_item.res.sequence_number = {hdr_r[15], hdr_r[14], hdr_r[13], hdr_r[12]};
        mid_item.res.body_length     = body_len;
        mid_item.res.minor_version   = hdr_r[3];
      end
    end

    cnt_nxt = cnt_r;
    if (accept) begin
      if (in_data.last_byte) begin
        cnt_nxt = '0;
      end else if (cnt_r != fdc32_pkg::COUNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r           <= '0;
      start_word_r    <= 16'd0;
      major_version_r <= 8'd1;
    end else begin
      cnt_r <= cnt_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_addr)
          fdc32_pkg::REG_START_WORD:    start_word_r    <= cfg_wdata;
          fdc32_pkg::REG_MAJOR_VERSION: major_version_r <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_payload) begin
      hdr_r[cnt_r[fdc32_pkg::HDR_IDX_W-1:0]] <= in_data.rx_byte;
    end
  end

endmodule

// ----- sv/fdc32_back.sv -----
// Back end: running payload CRC and final CRC verdict on the last beat.
module fdc32_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mid_empty,
  input  fdc32_pkg::mid_item_t mid_item,
  output logic                 mid_pop,
  input  logic                 out_full,
  output logic                 out_push,
  output fdc32_pkg::out_item_t out_item
);

  logic [31:0] crc_r, crc_nxt, crc_upd;
  logic        mismatch;

  assign mid_pop  = !mid_empty && !out_full;
  assign out_push = mid_pop;

  always_comb begin
    crc_upd  = fdc32_pkg::crc_byte(crc_r, mid_item.res.payload_byte);
    crc_nxt  = mid_item.res.payload_valid ? crc_upd : crc_r;
    mismatch = mid_item.body_nz ? ((~crc_nxt) != mid_item.hdr_crc)
                                : (mid_item.hdr_crc != 32'd0);
    out_item = mid_item.res;
    if (mid_item.res.frame_done && mid_item.crc_chk) begin
      out_item.status = mismatch ? fdc32_pkg::ST_CRC_ERR : fdc32_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= fdc32_pkg::CRC_INIT;
    end else if (mid_pop) begin
      crc_r <= mid_item.res.frame_done ? fdc32_pkg::CRC_INIT : crc_nxt;
    end
  end

endmodule
